// ----- hw/rtl/fat12_cluster_chain_step_assert.svh -----
// ----------------------------------------------------------------------------
// fat12 cluster chain step: assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_STEP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_STEP_ASSERT_SVH

// same-cycle implication
`define FAT12_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("fat12 assertion failed");

// next-cycle implication
`define FAT12_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("fat12 assertion failed");

`endif

// ----- hw/rtl/fat12_pkg.sv -----
// ----------------------------------------------------------------------------
// fat12_pkg
// shared types and constants of the fat12 cluster chain step block
// ----------------------------------------------------------------------------
package fat12_pkg;

  localparam int FAT_BYTES_DEF = 8192;

  // store addresses are widened to this many bits before range checks
  localparam int EXT_AW = 17;

  localparam int APB_AW = 5;
  localparam int LBA_W  = 20;

  // root directory sector division: dividend and remainder widths
  localparam int QUO_W = 22;
  localparam int REM_W = 13;
  localparam int CNT_W = $clog2(QUO_W);

  localparam logic [11:0] CLUSTER_MASK = 12'hfff;
  localparam logic [11:0] END_MARK     = 12'hFF8;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic ST_OK          = 1'b0;
  localparam logic ST_BAD_CLUSTER = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
  localparam logic [2:0] REG_SECTORS_PER_FAT     = 3'd4;
  localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd5;

  typedef enum logic [1:0] {
    GS_LOAD,
    GS_DIV,
    GS_DONE
  } geom_state_t;

  // geometry handed from the register block to the lookup path
  typedef struct packed {
    logic             ready;
    logic [7:0]       spc;
    logic [LBA_W-1:0] first_data;
  } geom_t;

endpackage

// ----- hw/rtl/fat12_store.sv -----
// ----------------------------------------------------------------------------
// fat12_store
// FAT byte store split into even and odd byte banks so that the two bytes of
// an entry come out of a single read; read data is registered
// ----------------------------------------------------------------------------
module fat12_store #(
  parameter int FAT_BYTES = fat12_pkg::FAT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [12:0] wr_addr,
  input  logic [7:0]  wr_data,
  input  logic        rd_en,
  input  logic [12:0] rd_off,
  output logic [7:0]  lo_byte,
  output logic [7:0]  hi_byte
);

  localparam int XW         = fat12_pkg::EXT_AW;
  localparam int EVEN_DEPTH = (FAT_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = FAT_BYTES / 2;
  localparam int EW         = $clog2(EVEN_DEPTH);
  localparam int OW         = $clog2(ODD_DEPTH);
  localparam logic [XW-1:0] LIMIT = XW'(FAT_BYTES);

  logic [7:0] even_mem [EVEN_DEPTH];
  logic [7:0] odd_mem  [ODD_DEPTH];

  logic [XW-1:0] wr_ext;
  logic          wr_in;
  logic [XW-1:0] lo_ext;
  logic [XW-1:0] hi_ext;
  logic [XW-1:0] even_ext;
  logic [XW-1:0] odd_ext;

  logic [7:0] even_q_r;
  logic [7:0] odd_q_r;
  logic       sel_r;
  logic       lo_ok_r;
  logic       hi_ok_r;

  assign wr_ext = XW'(wr_addr);
  assign wr_in  = wr_ext < LIMIT;

  assign lo_ext   = XW'(rd_off);
  assign hi_ext   = lo_ext + XW'(1);
  // an odd offset starts in the odd bank and ends in the next even row
  assign even_ext = rd_off[0] ? hi_ext : lo_ext;
  assign odd_ext  = rd_off[0] ? lo_ext : hi_ext;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in && !wr_ext[0]) begin
      even_mem[wr_ext[EW:1]] <= wr_data;
    end
    if (rd_en) begin
      even_q_r <= even_mem[even_ext[EW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_in && wr_ext[0]) begin
      odd_mem[wr_ext[OW:1]] <= wr_data;
    end
    if (rd_en) begin
      odd_q_r <= odd_mem[odd_ext[OW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_r   <= rd_off[0];
      lo_ok_r <= lo_ext < LIMIT;
      hi_ok_r <= hi_ext < LIMIT;
    end
  end

  // bytes past the end of the store read as zero
  assign lo_byte = !lo_ok_r ? 8'd0 : (sel_r ? odd_q_r : even_q_r);
  assign hi_byte = !hi_ok_r ? 8'd0 : (sel_r ? even_q_r : odd_q_r);

endmodule

// ----- hw/rtl/fat12_geom.sv -----
// ----------------------------------------------------------------------------
// fat12_geom
// volume geometry registers on the apb port and the first data sector,
// recomputed with a bit-serial divider after reset and after every write
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_step_assert.svh"

module fat12_geom (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fat12_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output fat12_pkg::geom_t              geom
);

  localparam int QW = fat12_pkg::QUO_W;
  localparam int RW = fat12_pkg::REM_W;
  localparam int CW = fat12_pkg::CNT_W;
  localparam int LW = fat12_pkg::LBA_W;

  logic [12:0] bytes_per_sector_r;
  logic [7:0]  sectors_per_cluster_r;
  logic [15:0] reserved_sectors_r;
  logic [2:0]  fat_copies_r;
  logic [15:0] sectors_per_fat_r;
  logic [15:0] root_entries_r;

  fat12_pkg::geom_state_t state_r, state_nxt;

  logic [QW-1:0] quo_r;
  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] base_r;
  logic          zero_div_r;
  logic [LW-1:0] first_data_r;

  logic          wr_acc;
  logic [2:0]    reg_idx;
  logic [18:0]   fat_secs;
  logic [LW-1:0] base_w;
  logic [QW-1:0] dividend;
  logic [RW:0]   shifted;
  logic          ge;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic          last_step;

  assign pready  = 1'b1;
  assign wr_acc  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[fat12_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_per_sector_r    <= 13'd512;
      sectors_per_cluster_r <= 8'd1;
      reserved_sectors_r    <= 16'd1;
      fat_copies_r          <= 3'd2;
      sectors_per_fat_r     <= 16'd9;
      root_entries_r        <= 16'd224;
    end else if (wr_acc) begin
      unique case (reg_idx)
        fat12_pkg::REG_BYTES_PER_SECTOR:    bytes_per_sector_r    <= pwdata[12:0];
        fat12_pkg::REG_SECTORS_PER_CLUSTER: sectors_per_cluster_r <= pwdata[7:0];
        fat12_pkg::REG_RESERVED_SECTORS:    reserved_sectors_r    <= pwdata[15:0];
        fat12_pkg::REG_FAT_COPIES:          fat_copies_r          <= pwdata[2:0];
        fat12_pkg::REG_SECTORS_PER_FAT:     sectors_per_fat_r     <= pwdata[15:0];
        fat12_pkg::REG_ROOT_ENTRIES:        root_entries_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fat12_pkg::REG_BYTES_PER_SECTOR:    prdata = 32'(bytes_per_sector_r);
      fat12_pkg::REG_SECTORS_PER_CLUSTER: prdata = 32'(sectors_per_cluster_r);
      fat12_pkg::REG_RESERVED_SECTORS:    prdata = 32'(reserved_sectors_r);
      fat12_pkg::REG_FAT_COPIES:          prdata = 32'(fat_copies_r);
      fat12_pkg::REG_SECTORS_PER_FAT:     prdata = 32'(sectors_per_fat_r);
      fat12_pkg::REG_ROOT_ENTRIES:        prdata = 32'(root_entries_r);
      default:                            prdata = 32'd0;
    endcase
  end

  // reserved + fat area, modulo the lba width
  assign fat_secs = fat_copies_r * sectors_per_fat_r;
  assign base_w   = LW'(reserved_sectors_r) + LW'(fat_secs);
  // root bytes rounded up to whole sectors
  assign dividend = {1'b0, root_entries_r, 5'b0} + QW'(bytes_per_sector_r) - QW'(1);

  // one restoring division step per cycle
  assign shifted   = {rem_r, quo_r[QW-1]};
  assign ge        = shifted >= {1'b0, bytes_per_sector_r};
  assign diff      = shifted - {1'b0, bytes_per_sector_r};
  assign rem_nxt   = ge ? diff[RW-1:0] : shifted[RW-1:0];
  assign quo_nxt   = {quo_r[QW-2:0], ge};
  assign last_step = cnt_r == CW'(0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fat12_pkg::GS_LOAD: state_nxt = fat12_pkg::GS_DIV;
      fat12_pkg::GS_DIV:  if (last_step) state_nxt = fat12_pkg::GS_DONE;
      fat12_pkg::GS_DONE: state_nxt = fat12_pkg::GS_DONE;
      default:            state_nxt = fat12_pkg::GS_LOAD;
    endcase
    if (wr_acc) begin
      state_nxt = fat12_pkg::GS_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fat12_pkg::GS_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fat12_pkg::GS_LOAD) begin
      quo_r      <= dividend;
      rem_r      <= '0;
      cnt_r      <= CW'(QW - 1);
      base_r     <= base_w;
      zero_div_r <= bytes_per_sector_r == 13'd0;
    end else if (state_r == fat12_pkg::GS_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
      if (last_step) begin
        first_data_r <= base_r + (zero_div_r ? LW'(0) : quo_nxt[LW-1:0]);
      end
    end
  end

  assign geom.ready      = state_r == fat12_pkg::GS_DONE;
  assign geom.spc        = sectors_per_cluster_r;
  assign geom.first_data = first_data_r;

  `FAT12_ASSERT_NEXT(a_write_drops_ready, clk, rst_n, wr_acc, !geom.ready)
  `FAT12_ASSERT_IMPL(a_ready_after_div, clk, rst_n, geom.ready && !$past(geom.ready), $past(state_r == fat12_pkg::GS_DIV && last_step && !wr_acc))

endmodule

// ----- hw/rtl/fat12_cluster_chain_step.sv -----
// ----------------------------------------------------------------------------
// fat12_cluster_chain_step
// FAT12 next-cluster lookup with first data sector address of the cluster
// ----------------------------------------------------------------------------
// One transaction per clock while busy is low: a load writes one byte into
// the FAT store and gives no result; a lookup gives one result through the
// s1 and output registers, shown for one cycle with out_valid, and the
// receiver cannot stall it. Lookups and loads may follow each other in every
// cycle; a load is visible to a lookup taken in the very next cycle, since
// both use the store at their accept edge. busy is high after reset and after
// every register write, while a bit-serial divider (22 steps) works out the
// root directory size and the first data sector; the user must write registers
// only while the block is idle, and the block itself does not enforce it.
`include "fat12_cluster_chain_step_assert.svh"

module fat12_cluster_chain_step #(
  parameter int FAT_BYTES = fat12_pkg::FAT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic [12:0]                  in_fat_address,
  input  logic [7:0]                   in_fat_byte,
  input  logic [11:0]                  in_cluster,
  output logic                         out_valid,
  output logic [11:0]                  out_next_cluster,
  output logic [19:0]                  out_sector_lba,
  output logic                         out_end_of_chain,
  output logic                         out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fat12_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int LW = fat12_pkg::LBA_W;

  fat12_pkg::geom_t geom;

  logic        accept;
  logic        load_acc;
  logic        lookup_acc;
  logic [11:0] cl_m2;
  logic [LW-1:0] prod_w;
  logic [12:0] entry_off;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [15:0] word;
  logic [11:0] next_w;

  logic          s1_valid_r;
  logic          s1_odd_r;
  logic          s1_bad_r;
  logic [LW-1:0] s1_prod_r;

  logic        out_valid_r;
  logic [11:0] out_next_r;
  logic [19:0] out_lba_r;
  logic        out_eoc_r;
  logic        out_status_r;

  fat12_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (geom)
  );

  assign busy       = !geom.ready;
  assign accept     = start && !busy;
  assign load_acc   = accept && (in_opcode == fat12_pkg::OP_LOAD);
  assign lookup_acc = accept && (in_opcode == fat12_pkg::OP_LOOKUP);

  // entry offset is cluster * 3 / 2
  assign entry_off = 13'(in_cluster) + 13'(in_cluster[11:1]);

  fat12_store #(
    .FAT_BYTES (FAT_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (in_fat_address),
    .wr_data (in_fat_byte),
    .rd_en   (lookup_acc),
    .rd_off  (entry_off),
    .lo_byte (lo_byte),
    .hi_byte (hi_byte)
  );

  assign cl_m2  = in_cluster - fat12_pkg::FIRST_DATA_CLUSTER;
  assign prod_w = {8'd0, cl_m2} * {12'd0, geom.spc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= lookup_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      s1_odd_r  <= in_cluster[0];
      s1_bad_r  <= (in_cluster < fat12_pkg::FIRST_DATA_CLUSTER) ||
                   (in_cluster >= fat12_pkg::END_MARK);
      s1_prod_r <= prod_w;
    end
  end

  assign word   = {hi_byte, lo_byte};
  assign next_w = (s1_odd_r ? word[15:4] : word[11:0]) & fat12_pkg::CLUSTER_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      if (s1_bad_r) begin
        out_next_r   <= 12'd0;
        out_lba_r    <= 20'd0;
        out_eoc_r    <= 1'b0;
        out_status_r <= fat12_pkg::ST_BAD_CLUSTER;
      end else begin
        out_next_r   <= next_w;
        out_lba_r    <= s1_prod_r + geom.first_data;
        out_eoc_r    <= next_w >= fat12_pkg::END_MARK;
        out_status_r <= fat12_pkg::ST_OK;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_cluster = out_next_r;
  assign out_sector_lba   = out_lba_r;
  assign out_end_of_chain = out_eoc_r;
  assign out_status       = out_status_r;

  `FAT12_ASSERT_IMPL(a_result_follows_lookup, clk, rst_n, 1'b1, out_valid_r == $past(lookup_acc, 2))
  `FAT12_ASSERT_IMPL(a_bad_result_zeroed, clk, rst_n, out_valid_r && (out_status_r == fat12_pkg::ST_BAD_CLUSTER), (out_next_r == 12'd0) && (out_lba_r == 20'd0) && !out_eoc_r)
  `FAT12_ASSERT_NEXT(a_no_accept_while_busy, clk, rst_n, busy, !$past(accept))

endmodule
